/* rtl/core/iidl_pkg.sv */
`default_nettype none
package iidl_pkg;

  localparam int DEPTH = 64;

  // Count runs from zero to DEPTH inclusive, a cell index from zero to DEPTH-1.
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam int OP_W    = 2;
  localparam int POS_W   = 7;
  localparam int DATA_W  = 32;
  localparam int ST_W    = 2;
  localparam int ECNT_W  = 7;

  // Position compares are made at a width that holds both a position and a count.
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] item;
  } req_t;

  typedef struct packed {
    logic [ST_W-1:0]          status;
    logic signed [DATA_W-1:0] read_value;
    logic [ECNT_W-1:0]        entry_count;
  } rsp_t;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    logic             ins;
    logic             del;
    logic [CMP_W-1:0] position;
  } cell_cmd_t;

endpackage
`default_nettype wire

/* rtl/core/iidl_cell.sv */
`default_nettype none
module iidl_cell (
  input  wire                           clk,
  input  wire  [iidl_pkg::IDX_W-1:0]    idx,
  input  wire  iidl_pkg::cell_cmd_t     cmd,
  input  wire  [iidl_pkg::DATA_W-1:0]   item,
  input  wire  [iidl_pkg::DATA_W-1:0]   from_left,
  input  wire  [iidl_pkg::DATA_W-1:0]   from_right,
  output logic [iidl_pkg::DATA_W-1:0]   entry,
  output logic [iidl_pkg::DATA_W-1:0]   read_term
);
  import iidl_pkg::*;

  logic [CMP_W-1:0] idx_ext;
  logic             hit;
  logic             above;

  assign idx_ext = CMP_W'(idx);
  assign hit     = (idx_ext == cmd.position);
  assign above   = (idx_ext > cmd.position);

  // An insert opens a gap at the named position by moving every later entry up
  // one cell; a delete closes it by moving every later entry down.
  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (hit) begin
        entry <= item;
      end else if (above) begin
        entry <= from_left;
      end
    end else if (cmd.del) begin
      if (hit || above) begin
        entry <= from_right;
      end
    end
  end

  assign read_term = hit ? entry : '0;

endmodule
`default_nettype wire

/* rtl/core/indexed_insert_delete_list_core.sv */
`default_nettype none
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready  | in_data  (operation, position, item)
// out     | output    | out_valid / out_ready| out_data (status, read_value, entry_count)
//
// The whole row of cells shifts in parallel at the edge that accepts an item,
// and its result appears in the output register at that
// same edge.
// An item is taken in every cycle while the output register is empty or being
// emptied; a stalled output holds the input off.
// Reset clears the count and the output valid flag; cell contents are left as
// they are and are never read before being written.
module indexed_insert_delete_list_core (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire  iidl_pkg::req_t in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output iidl_pkg::rsp_t       out_data
);
  import iidl_pkg::*;

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic              accept;
  logic [CMP_W-1:0]  pos_ext;
  logic [CMP_W-1:0]  cnt_ext;
  logic              full;
  logic              empty;
  logic [ST_W-1:0]   status_next;
  logic              is_read_ok;
  cell_cmd_t         cmd;
  logic [DATA_W-1:0] read_or;
  rsp_t              rsp_next;

  logic [DATA_W-1:0] entries    [DEPTH];
  logic [DATA_W-1:0] read_terms [DEPTH];

  assign accept  = in_valid && in_ready;
  assign in_ready = !out_valid || out_ready;

  assign pos_ext = CMP_W'(in_data.position);
  assign cnt_ext = CMP_W'(count);
  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);

  always_comb begin
    cmd.ins      = 1'b0;
    cmd.del      = 1'b0;
    cmd.position = pos_ext;
    status_next  = ST_BADPOS;
    is_read_ok   = 1'b0;
    count_next   = count;
    case (in_data.operation)
      OP_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else if (pos_ext <= cnt_ext) begin
          status_next = ST_OK;
          cmd.ins     = accept;
          count_next  = count + CNT_W'(1);
        end
      end
      OP_DELETE: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else if (pos_ext < cnt_ext) begin
          status_next = ST_OK;
          cmd.del     = accept;
          count_next  = count - CNT_W'(1);
        end
      end
      OP_READ: begin
        if (pos_ext < cnt_ext) begin
          status_next = ST_OK;
          is_read_ok  = 1'b1;
        end
      end
      default: begin
        status_next = ST_BADPOS;
      end
    endcase
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_W-1:0] left_in;
    logic [DATA_W-1:0] right_in;
    if (g == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_mid_l
      assign left_in = entries[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_mid_r
      assign right_in = entries[g+1];
    end
    iidl_cell u_cell (
      .clk        (clk),
      .idx        (IDX_W'(g)),
      .cmd        (cmd),
      .item       (in_data.item),
      .from_left  (left_in),
      .from_right (right_in),
      .entry      (entries[g]),
      .read_term  (read_terms[g])
    );
  end

  // At most one cell matches the position, so the terms can simply be ORed.
  always_comb begin
    read_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      read_or = read_or | read_terms[i];
    end
  end

  always_comb begin
    rsp_next.status      = status_next;
    rsp_next.read_value  = is_read_ok ? read_or : '0;
    rsp_next.entry_count = ECNT_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= rsp_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(count))
    else $error("entry count moved without an item");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    accept |=> (count == $past(count) || count == $past(count) + CNT_W'(1)
                || count == $past(count) - CNT_W'(1)))
    else $error("entry count moved by more than one");

  a_result_count: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid && out_data.entry_count == ECNT_W'(count))
    else $error("result count differs from stored count");

  a_ok_changes: assert property (@(posedge clk) disable iff (rst)
    accept && status_next != ST_OK |=> $stable(count))
    else $error("rejected item changed the count");

endmodule
`default_nettype wire

/* bench/indexed_insert_delete_list_core_test.sv */
module indexed_insert_delete_list_core_test;
  import iidl_pkg::*;

  // The block has no name for the spare operation code.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1650;
  localparam int HOLD_OFF_CYCLES = 400;

  typedef enum {PH_FILL, PH_DRAIN, PH_MIXED, PH_READS} phase_kind_t;

  // Tracks the list contents and the results that are still due from the block.
  class list_tracker_t;
    logic signed [DATA_W-1:0] cells [DEPTH];
    int count;
    int failures;
    rsp_t expected_results [$];

    function new();
      count = 0;
      failures = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void note_request(req_t r);
      rsp_t e;
      int p;
      int i;
      e.status = ST_BADPOS;
      e.read_value = '0;
      p = r.position;
      case (r.operation)
        OP_INSERT: begin
          if (count >= DEPTH) begin
            e.status = ST_FULL;
          end else if (p <= count) begin
            for (i = count; i > p; i--) cells[i] = cells[i-1];
            cells[p] = r.item;
            count++;
            e.status = ST_OK;
          end
        end
        OP_DELETE: begin
          if (count == 0) begin
            e.status = ST_EMPTY;
          end else if (p < count) begin
            for (i = p; i + 1 < count; i++) cells[i] = cells[i+1];
            count--;
            e.status = ST_OK;
          end
        end
        OP_READ: begin
          if (p < count) begin
            e.read_value = cells[p];
            e.status = ST_OK;
          end
        end
        default: begin
        end
      endcase
      e.entry_count = ECNT_W'(count);
      expected_results.push_back(e);
    endfunction

    function void check_result(rsp_t got);
      rsp_t e;
      if (expected_results.size() == 0) begin
        $error("result arrived with no request outstanding");
        failures++;
        return;
      end
      e = expected_results.pop_front();
      if (got.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, got.status);
        failures++;
      end
      if (got.read_value !== e.read_value) begin
        $error("read_value: expected %0d, got %0d", e.read_value, got.read_value);
        failures++;
      end
      if (got.entry_count !== e.entry_count) begin
        $error("entry_count: expected %0d, got %0d", e.entry_count, got.entry_count);
        failures++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  req_t in_data;
  logic out_valid;
  logic out_ready;
  rsp_t out_data;

  list_tracker_t tracker;
  bit sender_burst;
  bit hold_off_req;
  bit hold_active;

  indexed_insert_delete_list_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Mostly back to back, sometimes a short gap, now and then a long one.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  function automatic req_t build_request(logic [OP_W-1:0] op, int pos,
                                         logic [DATA_W-1:0] value);
    req_t r;
    r.operation = op;
    r.position = POS_W'(pos);
    r.item = value;
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] random_value();
    case ($urandom_range(0, 19))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Most positions fall inside the list; the rest are spread over the whole field.
  function automatic req_t random_request(int ins_pct, int del_pct);
    logic [OP_W-1:0] op;
    int r;
    int limit;
    int pos;
    if ($urandom_range(0, 99) < 3) begin
      op = OP_UNUSED;
    end else begin
      r = $urandom_range(0, 99);
      if (r < ins_pct) op = OP_INSERT;
      else if (r < ins_pct + del_pct) op = OP_DELETE;
      else op = OP_READ;
    end
    limit = (op == OP_INSERT) ? tracker.count : tracker.count - 1;
    if (limit < 0 || $urandom_range(0, 99) < 12) pos = $urandom_range(0, 2**POS_W - 1);
    else pos = $urandom_range(0, limit);
    return build_request(op, pos, random_value());
  endfunction

  // Entered and left at a falling edge.
  task automatic send_request(req_t r);
    int gap;
    gap = sender_burst ? 0 : idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (tracker.pending() != 0);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) tracker.check_result(out_data);
      if (in_valid && in_ready) tracker.note_request(in_data);
    end
  end

  // Receiver: random stalls, bursts of steady acceptance and one long hold-off.
  initial begin : receiver
    int n;
    bit rx_burst;
    rx_burst = 1'b0;
    out_ready = 1'b0;
    wait (!rst);
    forever begin
      if ($urandom_range(0, 199) == 0) rx_burst = !rx_burst;
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_active = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_active = 1'b0;
      end else begin
        n = rx_burst ? 0 : idle_gap();
        if (n > 0) begin
          out_ready <= 1'b0;
          repeat (n) @(negedge clk);
        end
      end
      out_ready <= 1'b1;
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int sent;
    int n;
    int extra;
    int ins_pct;
    int del_pct;
    int waited;
    bit first_phase;
    phase_kind_t kind;

    tracker = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    sender_burst = 1'b0;
    hold_off_req = 1'b0;
    hold_active = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: the empty list, appends, the field extremes and the empty and bad-position rejections.
    send_request(build_request(OP_READ, 0, 32'h1234_5678));
    send_request(build_request(OP_DELETE, 0, '0));
    send_request(build_request(OP_DELETE, 127, '1));
    send_request(build_request(OP_UNUSED, 127, '1));
    send_request(build_request(OP_INSERT, 1, 32'h5555_5555));
    send_request(build_request(OP_INSERT, 0, 32'h7fff_ffff));
    send_request(build_request(OP_INSERT, 1, 32'h8000_0000));
    send_request(build_request(OP_INSERT, 0, '0));
    send_request(build_request(OP_INSERT, 3, '1));
    send_request(build_request(OP_INSERT, 5, 32'haaaa_aaaa));
    send_request(build_request(OP_INSERT, 127, 32'h0f0f_0f0f));
    send_request(build_request(OP_READ, 0, '0));
    send_request(build_request(OP_READ, 1, '0));
    send_request(build_request(OP_READ, 2, '0));
    send_request(build_request(OP_READ, 3, '0));
    send_request(build_request(OP_READ, 4, '0));
    send_request(build_request(OP_READ, 127, '0));
    send_request(build_request(OP_DELETE, 4, '0));
    send_request(build_request(OP_DELETE, 127, '0));
    send_request(build_request(OP_DELETE, 1, '0));
    send_request(build_request(OP_READ, 1, '0));
    send_request(build_request(OP_UNUSED, 0, '0));
    send_request(build_request(OP_DELETE, 2, '0));
    send_request(build_request(OP_READ, 64, '0));
    wait_drained();

    // The receiver holds off while items keep coming, so the input backs up.
    hold_off_req = 1'b1;
    wait (hold_active);
    sender_burst = 1'b1;
    sent = 0;
    repeat (30) begin
      send_request(random_request(60, 20));
      sent++;
    end
    wait_drained();

    first_phase = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      if (first_phase) kind = PH_FILL;
      else kind = phase_kind_t'($urandom_range(0, 3));
      first_phase = 1'b0;
      sender_burst = ($urandom_range(0, 2) == 0);
      case (kind)
        PH_FILL:  begin ins_pct = 80; del_pct = 10; end
        PH_DRAIN: begin ins_pct = 10; del_pct = 80; end
        PH_MIXED: begin ins_pct = 40; del_pct = 35; end
        default:  begin ins_pct = 20; del_pct = 15; end
      endcase
      n = 0;
      extra = 0;
      while (n < 300 && extra < 8 && sent < RANDOM_ITEMS) begin
        send_request(random_request(ins_pct, del_pct));
        n++;
        sent++;
        if ((kind == PH_FILL && tracker.count == DEPTH) ||
            (kind == PH_DRAIN && tracker.count == 0) ||
            (kind != PH_FILL && kind != PH_DRAIN && n >= 60)) extra++;
      end
      if ($urandom_range(0, 3) == 0) wait_drained();
    end

    in_valid <= 1'b0;
    waited = 0;
    while (tracker.pending() != 0 && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
    repeat (10) @(negedge clk);
    if (tracker.pending() != 0) begin
      $error("%0d results never arrived", tracker.pending());
      tracker.failures++;
    end
    if (tracker.failures == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* indexed_insert_delete_list_core.f */
rtl/core/iidl_pkg.sv
rtl/core/iidl_cell.sv
rtl/core/indexed_insert_delete_list_core.sv
bench/indexed_insert_delete_list_core_test.sv
